### hdl/assert_macros.svh
// Assertion macros for the biquad cascade block.
// Included by the modules that check their own sequencing; needs aclk and aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property outside reset
`define ASSERT_CLK(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("assertion failed");

// check a property at every edge, reset included
`define ASSERT_RST(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("assertion failed");

`endif

### hdl/mbc_pkg.sv
// Shared types and constants for the multichannel biquad cascade.
// Holds the sequencer state type, command codes and the Q2.30 coefficient ROM.
package mbc_pkg;

    localparam int SEC_W   = 3;
    localparam int DELAY_W = 48;
    localparam int ROM_FRAC = 30;
    localparam int STATE_FRAC = 16;

    localparam logic CMD_FILTER = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    typedef enum logic [2:0] {
        K_B0 = 3'd0,
        K_B1 = 3'd1,
        K_B2 = 3'd2,
        K_A1 = 3'd3,
        K_A2 = 3'd4
    } coef_idx_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_MUL4,
        ST_WRITE,
        ST_OUT
    } seq_state_t;

    // b0, b1, b2, a1, a2 per section
    localparam logic signed [31:0] COEF_ROM [0:7][0:4] = '{
        '{ 32'sd1047511882, -32'sd2095023764, 32'sd1047511882,
          -32'sd2092954696, 32'sd1023351008 },
        '{ 32'sd1013867113, -32'sd2027734226, 32'sd1013867113,
          -32'sd2025731615, 32'sd955995012 },
        '{ 32'sd1067064796, -32'sd2107854914, 32'sd1067064796,
          -32'sd2107854914, 32'sd1060387767 },
        '{ 32'sd1060631695, -32'sd2017441371, 32'sd1060631695,
          -32'sd2017441371, 32'sd1047521566 },
        '{ 32'sd1054590855, -32'sd1879294664, 32'sd1054590855,
          -32'sd1879294664, 32'sd1035439886 },
        '{ 32'sd1073741824, 32'sd0, 32'sd0, 32'sd0, 32'sd0 },
        '{ 32'sd1073741824, 32'sd0, 32'sd0, 32'sd0, 32'sd0 },
        '{ 32'sd1073741824, 32'sd0, 32'sd0, 32'sd0, 32'sd0 }
    };

endpackage

### hdl/multichannel_biquad_cascade_unit.sv
// Multichannel biquad cascade: high-pass plus notch filtering of tagged samples.
// Depends on mbc_pkg and assert_macros.svh.
//
// Usage:
//   Input stream s_*: s_tuser is the command (filter or clear), s_tdata carries
//   the channel and the signed sample. Output stream m_*: m_tdata carries the
//   channel and the filtered, saturated sample. A clear or an item on a channel
//   at or above NUM_CHANNELS gives no result.
//   One shared multiplier runs five products per section (ST_MUL0 to ST_MUL4,
//   then ST_WRITE). A new item is taken only after the last has left ST_OUT,
//   and a clear writes zero to the channel's NUM_SECTIONS delay entries.
//   s_tready is high only while the sequencer is idle.
//   After reset the delay memories are swept to zero, one entry a cycle,
//   all NUM_CHANNELS*NUM_SECTIONS entries, with s_tready low.
//   The result sits in an output register; while the receiver stalls, the next
//   item is still taken and computed, and waits for the register to empty.
`include "assert_macros.svh"

module multichannel_biquad_cascade_unit
    import mbc_pkg::*;
#(
    parameter int NUM_CHANNELS    = 8,
    parameter int NUM_SECTIONS    = 5,
    parameter int COEFF_FRAC_BITS = 30,
    parameter int SAMPLE_BITS     = 24
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // [2:0] channel, then sample_in, zero fill to bytes
    input  logic [((SAMPLE_BITS + 3 + 7) / 8) * 8 - 1:0] s_tdata,
    // [0] command
    input  logic s_tuser,
    output logic m_tvalid,
    input  logic m_tready,
    // [2:0] channel_out, then sample_out, zero fill to bytes
    output logic [((SAMPLE_BITS + 3 + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int TD_W     = ((SAMPLE_BITS + 3 + 7) / 8) * 8;
    localparam int DEPTH    = NUM_CHANNELS * NUM_SECTIONS;
    localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW       = COEFF_FRAC_BITS + 2;
    localparam int PW       = CW + SAMPLE_BITS;
    localparam int PW1      = PW + 1;
    localparam int ACC_W    = (SAMPLE_BITS + 20 > DELAY_W + 2) ? SAMPLE_BITS + 20 : DELAY_W + 2;
    localparam int ROM_SH   = ROM_FRAC - COEFF_FRAC_BITS;
    localparam int PROD_SH  = COEFF_FRAC_BITS - STATE_FRAC;

    localparam logic signed [32:0] ROM_RND = 33'((64'sd1 <<< ROM_SH) >>> 1);
    localparam logic signed [PW1-1:0] PROD_RND = PW1'((64'sd1 <<< PROD_SH) >>> 1);
    localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(64'sd1 <<< (STATE_FRAC - 1));
    localparam logic signed [ACC_W-1:0] S_MAX =
        (ACC_W'(1) <<< (SAMPLE_BITS - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] S_MIN = -S_MAX - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] D_MAX = (ACC_W'(1) <<< (DELAY_W - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] D_MIN = -D_MAX - ACC_W'(1);
    localparam logic [SEC_W-1:0] LAST_SEC = SEC_W'(NUM_SECTIONS - 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    function automatic logic signed [CW-1:0] coef_at(input logic [SEC_W-1:0] sec,
                                                    input coef_idx_t k);
        logic signed [32:0] w;
        w = 33'(COEF_ROM[sec][k]) + ROM_RND;
        return CW'(w >>> ROM_SH);
    endfunction

    function automatic logic signed [ACC_W-1:0] clamp(input logic signed [ACC_W-1:0] v,
                                                     input logic signed [ACC_W-1:0] lo,
                                                     input logic signed [ACC_W-1:0] hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    seq_state_t state_reg, state_next;
    logic [AW-1:0]    addr_reg, addr_next;
    logic [SEC_W-1:0] sec_reg, sec_next;
    logic [2:0]       ch_reg, ch_next;
    logic signed [SAMPLE_BITS-1:0] x_reg, x_next;
    logic signed [SAMPLE_BITS-1:0] y_reg, y_next;
    logic signed [ACC_W-1:0] acc1_reg, acc1_next;
    logic signed [ACC_W-1:0] acc2_reg, acc2_next;
    logic signed [PW-1:0]    prod_reg, prod_next;
    logic signed [DELAY_W-1:0] d1_rd_reg, d2_rd_reg;
    logic m_tvalid_reg, m_tvalid_next;
    logic [2:0] m_chan_reg, m_chan_next;
    logic signed [SAMPLE_BITS-1:0] m_samp_reg, m_samp_next;

    logic signed [DELAY_W-1:0] d1_mem [DEPTH];
    logic signed [DELAY_W-1:0] d2_mem [DEPTH];

    logic rd_en, wr_en;
    logic [AW-1:0] rd_addr;
    logic signed [DELAY_W-1:0] wr_d1, wr_d2;
    logic signed [CW-1:0] mul_coef;
    logic signed [SAMPLE_BITS-1:0] mul_val;
    logic signed [PW1-1:0] prod_rnd;
    logic signed [ACC_W-1:0] rp, w_sum, y_wide, acc2_fin;
    logic [2:0] in_chan;
    logic signed [SAMPLE_BITS-1:0] in_samp;
    logic ch_ok;
    logic [AW-1:0] in_base;
    logic [TD_W-1:0] tdata_out;

    assign in_chan = s_tdata[2:0];
    assign in_samp = s_tdata[3 +: SAMPLE_BITS];
    assign ch_ok   = (32'(in_chan) < NUM_CHANNELS);
    assign in_base = AW'(32'(in_chan) * NUM_SECTIONS);

    assign prod_rnd = PW1'(prod_reg) + PROD_RND;
    assign rp       = ACC_W'(prod_rnd >>> PROD_SH);
    assign w_sum    = rp + ACC_W'(d1_rd_reg);
    assign y_wide   = clamp((w_sum + HALF_LSB) >>> STATE_FRAC, S_MIN, S_MAX);
    assign acc2_fin = acc2_reg - rp;

    always_comb begin
        case (state_reg)
            ST_MUL1: begin
                mul_coef = coef_at(sec_reg, K_B1);
                mul_val  = x_reg;
            end
            ST_MUL2: begin
                mul_coef = coef_at(sec_reg, K_A1);
                mul_val  = y_reg;
            end
            ST_MUL3: begin
                mul_coef = coef_at(sec_reg, K_B2);
                mul_val  = x_reg;
            end
            ST_MUL4: begin
                mul_coef = coef_at(sec_reg, K_A2);
                mul_val  = y_reg;
            end
            default: begin
                mul_coef = coef_at(sec_reg, K_B0);
                mul_val  = x_reg;
            end
        endcase
        prod_next = PW'(mul_coef) * PW'(mul_val);
    end

    always_comb begin
        state_next    = state_reg;
        addr_next     = addr_reg;
        sec_next      = sec_reg;
        ch_next       = ch_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        acc1_next     = acc1_reg;
        acc2_next     = acc2_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_chan_next   = m_chan_reg;
        m_samp_next   = m_samp_reg;
        s_tready      = 1'b0;
        rd_en         = 1'b0;
        rd_addr       = addr_reg;
        wr_en         = 1'b0;
        wr_d1         = '0;
        wr_d2         = '0;
        case (state_reg)
            ST_INIT: begin
                wr_en = 1'b1;
                if (addr_reg == LAST_ADDR) begin
                    addr_next  = '0;
                    state_next = ST_IDLE;
                end else begin
                    addr_next = addr_reg + AW'(1);
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid && ch_ok) begin
                    addr_next = in_base;
                    sec_next  = '0;
                    ch_next   = in_chan;
                    x_next    = in_samp;
                    if (s_tuser == CMD_CLEAR) begin
                        state_next = ST_CLEAR;
                    end else begin
                        rd_en      = 1'b1;
                        rd_addr    = in_base;
                        state_next = ST_MUL0;
                    end
                end
            end
            ST_CLEAR: begin
                wr_en = 1'b1;
                if (sec_reg == LAST_SEC) begin
                    sec_next   = '0;
                    state_next = ST_IDLE;
                end else begin
                    sec_next  = sec_reg + SEC_W'(1);
                    addr_next = addr_reg + AW'(1);
                end
            end
            ST_MUL0: state_next = ST_MUL1;
            ST_MUL1: begin
                y_next     = SAMPLE_BITS'(y_wide);
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                acc1_next  = rp + ACC_W'(d2_rd_reg);
                state_next = ST_MUL3;
            end
            ST_MUL3: begin
                acc1_next  = acc1_reg - rp;
                state_next = ST_MUL4;
            end
            ST_MUL4: begin
                acc2_next  = rp;
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                wr_en  = 1'b1;
                wr_d1  = DELAY_W'(clamp(acc1_reg, D_MIN, D_MAX));
                wr_d2  = DELAY_W'(clamp(acc2_fin, D_MIN, D_MAX));
                x_next = y_reg;
                if (sec_reg == LAST_SEC) begin
                    sec_next   = '0;
                    state_next = ST_OUT;
                end else begin
                    sec_next   = sec_reg + SEC_W'(1);
                    addr_next  = addr_reg + AW'(1);
                    rd_en      = 1'b1;
                    rd_addr    = addr_reg + AW'(1);
                    state_next = ST_MUL0;
                end
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_chan_next   = ch_reg;
                    m_samp_next   = x_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_INIT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_INIT;
            addr_reg     <= '0;
            sec_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            addr_reg     <= addr_next;
            sec_reg      <= sec_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ch_reg     <= ch_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        acc1_reg   <= acc1_next;
        acc2_reg   <= acc2_next;
        prod_reg   <= prod_next;
        m_chan_reg <= m_chan_next;
        m_samp_reg <= m_samp_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            d1_mem[addr_reg] <= wr_d1;
            d2_mem[addr_reg] <= wr_d2;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            d1_rd_reg <= d1_mem[rd_addr];
            d2_rd_reg <= d2_mem[rd_addr];
        end
    end

    always_comb begin
        tdata_out = '0;
        tdata_out[2:0] = m_chan_reg;
        tdata_out[3 +: SAMPLE_BITS] = m_samp_reg;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = tdata_out;

    `ASSERT_RST(a_init_after_reset, !aresetn |=> state_reg == ST_INIT)
    `ASSERT_CLK(a_out_from_seq, $rose(m_tvalid) |-> $past(state_reg) == ST_OUT)
    `ASSERT_CLK(a_wr_in_range, wr_en |-> 32'(addr_reg) < DEPTH)
    `ASSERT_CLK(a_drop_bad_channel, s_tvalid && s_tready && !ch_ok |=> state_reg == ST_IDLE)

endmodule

### sim/mbc_cascade_checker.sv
// Scoreboard for the multichannel biquad cascade: watches both streams and
// predicts each filtered sample from its own copy of the per-channel delay state.
// Depends on mbc_pkg for the command codes, coefficient indexes and coefficient ROM.
module mbc_cascade_checker
    import mbc_pkg::*;
#(
    parameter int NUM_CHANNELS    = 8,
    parameter int NUM_SECTIONS    = 5,
    parameter int COEFF_FRAC_BITS = 30,
    parameter int SAMPLE_BITS     = 24,
    parameter int TDATA_W         = ((SAMPLE_BITS + 3 + 7) / 8) * 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,
    input  logic               s_tuser,
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [TDATA_W-1:0] m_tdata,
    output int                 fail_count,
    output int                 outstanding
);

    localparam int ROM_SHIFT  = ROM_FRAC - COEFF_FRAC_BITS;
    localparam int PROD_SHIFT = COEFF_FRAC_BITS - STATE_FRAC;
    localparam longint DLY_MAX = (longint'(1) << (DELAY_W - 1)) - 1;
    localparam longint DLY_MIN = -DLY_MAX - 1;
    localparam longint SMP_MAX = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    localparam longint SMP_MIN = -SMP_MAX - 1;

    typedef struct {
        logic [2:0]             channel;
        logic [SAMPLE_BITS-1:0] sample;
    } filtered_t;

    filtered_t pending_outputs[$];
    longint    first_dly  [NUM_CHANNELS][NUM_SECTIONS];
    longint    second_dly [NUM_CHANNELS][NUM_SECTIONS];

    function automatic longint clamp_to(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint coef_of(int sec, coef_idx_t k);
        longint raw;
        raw = longint'(COEF_ROM[sec % 8][k]);
        if (ROM_SHIFT == 0)
            return raw;
        return (raw + (longint'(1) << (ROM_SHIFT - 1))) >>> ROM_SHIFT;
    endfunction

    function automatic longint mul_round(longint c, longint v);
        if (PROD_SHIFT == 0)
            return c * v;
        return (c * v + (longint'(1) << (PROD_SHIFT - 1))) >>> PROD_SHIFT;
    endfunction

    // advance one channel through every section and return the last section output
    function automatic longint run_cascade(int ch, longint x_in);
        longint x, y, w;
        longint b0, b1, b2, a1, a2;
        x = x_in;
        for (int s = 0; s < NUM_SECTIONS; s++) begin
            b0 = coef_of(s, K_B0);
            b1 = coef_of(s, K_B1);
            b2 = coef_of(s, K_B2);
            a1 = coef_of(s, K_A1);
            a2 = coef_of(s, K_A2);
            w = mul_round(b0, x) + first_dly[ch][s];
            y = clamp_to((w + (longint'(1) << (STATE_FRAC - 1))) >>> STATE_FRAC,
                         SMP_MIN, SMP_MAX);
            first_dly[ch][s] = clamp_to(mul_round(b1, x) - mul_round(a1, y)
                                        + second_dly[ch][s], DLY_MIN, DLY_MAX);
            second_dly[ch][s] = clamp_to(mul_round(b2, x) - mul_round(a2, y),
                                         DLY_MIN, DLY_MAX);
            x = y;
        end
        return x;
    endfunction

    always @(posedge aclk) begin
        filtered_t got;
        filtered_t want;
        longint    y;
        int        ch;
        if (!aresetn) begin
            for (int c = 0; c < NUM_CHANNELS; c++)
                for (int s = 0; s < NUM_SECTIONS; s++) begin
                    first_dly[c][s]  = 0;
                    second_dly[c][s] = 0;
                end
            pending_outputs.delete();
            fail_count = 0;
            outstanding <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.channel = m_tdata[2:0];
                got.sample  = m_tdata[3 +: SAMPLE_BITS];
                if (pending_outputs.size() == 0) begin
                    $error("unexpected result: channel_out %0d sample_out %0d",
                           got.channel, $signed(got.sample));
                    fail_count++;
                end else begin
                    want = pending_outputs.pop_front();
                    if (got.channel !== want.channel) begin
                        $error("channel_out mismatch: expected %0d, actual %0d",
                               want.channel, got.channel);
                        fail_count++;
                    end
                    if (got.sample !== want.sample) begin
                        $error("sample_out mismatch: expected %0d, actual %0d",
                               $signed(want.sample), $signed(got.sample));
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready && int'(s_tdata[2:0]) < NUM_CHANNELS) begin
                ch = int'(s_tdata[2:0]);
                if (s_tuser == CMD_CLEAR) begin
                    for (int s = 0; s < NUM_SECTIONS; s++) begin
                        first_dly[ch][s]  = 0;
                        second_dly[ch][s] = 0;
                    end
                end else begin
                    y = run_cascade(ch, longint'($signed(s_tdata[3 +: SAMPLE_BITS])));
                    want.channel = s_tdata[2:0];
                    want.sample  = y[SAMPLE_BITS-1:0];
                    pending_outputs.push_back(want);
                end
            end
            outstanding <= pending_outputs.size();
        end
    end

endmodule

### sim/tb_multichannel_biquad_cascade_unit.sv
// Top of the biquad cascade regression: drives directed and random sample and
// clear items, stalls the result stream, and reports the verdict.
// Depends on mbc_pkg, multichannel_biquad_cascade_unit and mbc_cascade_checker.
module tb_multichannel_biquad_cascade_unit
    import mbc_pkg::*;
();

    localparam int ITEM_TARGET    = 1350;
    localparam int CALM_TAIL      = 150;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 40;
    localparam logic [23:0] S_MAX = 24'h7FFFFF;
    localparam logic [23:0] S_MIN = 24'h800000;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic        s_tuser  = CMD_FILTER;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    logic sender_idle_on   = 1'b1;
    logic receiver_idle_on = 1'b1;
    int   items_sent       = 0;
    int   stall_left       = 0;
    int   quiet_cycles     = 0;
    int   fail_count;
    int   outstanding;

    always #10 aclk = ~aclk;

    multichannel_biquad_cascade_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    mbc_cascade_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // stall the result stream in random bursts
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b1;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            if (stall_left == 1)
                m_tready <= 1'b1;
        end else if (receiver_idle_on && $urandom_range(0, 7) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(1, 19);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic send_item(input logic cmd, input logic [2:0] ch, input logic [23:0] smp);
        if (sender_idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {5'b0, smp, ch};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    initial begin
        int          kind;
        int          run_len;
        int          half_period;
        int          dc;
        logic [2:0]  ch;
        logic [23:0] smp;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // extremes and full-scale steps to drive the sections into saturation
        send_item(CMD_FILTER, 3'd0, 24'd0);
        send_item(CMD_FILTER, 3'd0, S_MAX);
        send_item(CMD_FILTER, 3'd0, S_MAX);
        send_item(CMD_FILTER, 3'd0, S_MIN);
        send_item(CMD_FILTER, 3'd0, S_MIN);
        send_item(CMD_FILTER, 3'd0, S_MAX);
        send_item(CMD_FILTER, 3'd0, S_MIN);
        send_item(CMD_CLEAR,  3'd0, 24'd0);
        send_item(CMD_FILTER, 3'd0, S_MIN);
        send_item(CMD_FILTER, 3'd0, 24'hFFFFFF);
        send_item(CMD_FILTER, 3'd0, 24'd1);
        for (int c = 1; c < 8; c++)
            send_item(CMD_FILTER, 3'(c), (c % 2) ? 24'h555555 : 24'hAAAAAA);
        send_item(CMD_CLEAR,  3'd7, S_MAX);
        send_item(CMD_FILTER, 3'd7, S_MAX);
        send_item(CMD_CLEAR,  3'd5, 24'hFFFFFF);
        send_item(CMD_FILTER, 3'd5, S_MIN);

        while (items_sent < ITEM_TARGET) begin
            sender_idle_on   <= ((items_sent / 120) % 3 != 2)
                                && (items_sent < ITEM_TARGET - CALM_TAIL);
            receiver_idle_on <= ((items_sent / 120) % 3 != 1)
                                && (items_sent < ITEM_TARGET - CALM_TAIL);
            ch = 3'($urandom_range(0, 7));
            if ($urandom_range(0, 19) == 0) begin
                send_item(CMD_CLEAR, ch, 24'($urandom));
            end else begin
                kind        = $urandom_range(0, 3);
                run_len     = $urandom_range(4, 24);
                half_period = $urandom_range(1, 25);
                dc          = int'($urandom_range(0, 4000000)) - 2000000;
                for (int i = 0; i < run_len; i++) begin
                    case (kind)
                        0: smp = 24'($urandom);
                        1: smp = 24'(dc + int'($urandom_range(0, 1023)) - 512);
                        2: smp = ((i / half_period) % 2) ? S_MAX : S_MIN;
                        default: begin
                            case ($urandom_range(0, 3))
                                0: smp = S_MAX;
                                1: smp = S_MIN;
                                2: smp = 24'd0;
                                default: smp = 24'hFFFFFF;
                            endcase
                        end
                    endcase
                    send_item(CMD_FILTER, ch, smp);
                end
            end
        end
        s_tvalid <= 1'b0;

        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
